### design/crc8_frame_receiver_macros.svh
// Assertion macros for the CRC-8 frame receiver.
`ifndef CRC8_FRAME_RECEIVER_MACROS_SVH
`define CRC8_FRAME_RECEIVER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define CRC8FR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc8fr assertion failed");

// Condition implies consequence in the next cycle.
`define CRC8FR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc8fr assertion failed");

`endif

### design/crc8fr_pkg.sv
// Types, constants and the CRC-8 byte update for the frame receiver.
package crc8fr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] CrcPoly = 8'h07;
  localparam logic [ByteW-1:0] CrcMsb = 8'h80;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_VALUE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STATUS_COMMAND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PARAM_COMMAND = 2'd2;

  localparam logic [ByteW-1:0] SYNC_RST = 8'hAA;
  localparam logic [ByteW-1:0] STATUS_CMD_RST = 8'hF0;
  localparam logic [ByteW-1:0] PARAM_CMD_RST = 8'h10;

  typedef struct packed {
    logic [ByteW-1:0] sync_value;
    logic [ByteW-1:0] status_command;
    logic [ByteW-1:0] param_command;
  } cfg_t;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_offset;
    logic             frame_done;
    logic             crc_good;
    logic [ByteW-1:0] frame_command;
    logic [ByteW-1:0] frame_length;
    logic             deliver;
  } result_t;

  function automatic logic [ByteW-1:0] crc_update(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if ((c & CrcMsb) != '0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### design/crc8fr_in_if.sv
// Input byte channel.
interface crc8fr_in_if;
  logic                           valid;
  logic                           ready;
  logic [crc8fr_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### design/crc8fr_out_if.sv
// Result channel.
interface crc8fr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           payload_valid;
  logic [crc8fr_pkg::ByteW-1:0]   payload_byte;
  logic [crc8fr_pkg::ByteW-1:0]   payload_offset;
  logic                           frame_done;
  logic                           crc_good;
  logic [crc8fr_pkg::ByteW-1:0]   frame_command;
  logic [crc8fr_pkg::ByteW-1:0]   frame_length;
  logic                           deliver;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_offset, output frame_done, output crc_good,
                  output frame_command, output frame_length, output deliver,
                  input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input payload_offset, input frame_done, input crc_good,
                input frame_command, input frame_length, input deliver,
                output ready);
endinterface

### design/crc8fr_cfg_if.sv
// Configuration write channel.
interface crc8fr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crc8fr_pkg::CfgIdxW-1:0]   index;
  logic [crc8fr_pkg::ByteW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/crc8fr_parser.sv
// Frame parse state and running CRC; one byte per step.
module crc8fr_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [crc8fr_pkg::ByteW-1:0]  rx_byte,
  input  crc8fr_pkg::cfg_t              cfg,
  output crc8fr_pkg::result_t           result
);

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  logic [2:0]                   phase_r, phase_nxt;
  logic [crc8fr_pkg::ByteW-1:0] cmd_r, cmd_nxt;
  logic [crc8fr_pkg::ByteW-1:0] len_r, len_nxt;
  logic [crc8fr_pkg::ByteW-1:0] cnt_r, cnt_nxt;
  logic [crc8fr_pkg::ByteW-1:0] crc_r, crc_nxt;
  logic [crc8fr_pkg::ByteW:0]   cnt_inc;
  logic [crc8fr_pkg::ByteW-1:0] crc_step;
  logic                         good;
  logic                         accepted;

  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign crc_step = crc8fr_pkg::crc_update(crc_r, rx_byte);
  assign good     = (rx_byte == crc_r);
  assign accepted = (cmd_r == cfg.status_command) || (cmd_r == cfg.param_command);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    result    = '0;
    unique case (phase_r)
      PH_WAIT: begin
        if (rx_byte == cfg.sync_value) begin
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        crc_nxt   = crc8fr_pkg::crc_update('0, rx_byte);
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        cnt_nxt   = '0;
        crc_nxt   = crc_step;
        phase_nxt = (rx_byte == '0) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        result.payload_valid  = 1'b1;
        result.payload_byte   = rx_byte;
        result.payload_offset = cnt_r;
        crc_nxt               = crc_step;
        if (cnt_inc >= {1'b0, len_r}) begin
          phase_nxt = PH_CRC;
        end
        cnt_nxt = cnt_inc[crc8fr_pkg::ByteW-1:0];
      end
      PH_CRC: begin
        result.frame_done    = 1'b1;
        result.crc_good      = good;
        result.frame_command = cmd_r;
        result.frame_length  = len_r;
        result.deliver       = good && accepted;
        phase_nxt = (rx_byte == cfg.sync_value) ? PH_CMD : PH_WAIT;
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      cmd_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

### design/crc8_frame_receiver.sv
// CRC-8 length-prefixed frame receiver, top level.
//
//  channel  dir  handshake     beat contents
//  in_ch    in   valid/ready   rx_byte
//  out_ch   out  valid/ready   payload and end-of-frame report, one per input beat
//  cfg_ch   in   valid/ready   register index, write data
//
// Each input beat yields one result beat in the next cycle, through the output register.
// One beat per cycle sustained while out_ch.ready stays high; the parse step and CRC byte update are combinational.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// rst_n is synchronous: parse state to waiting for sync, registers to defaults.
// cfg_ch is always ready.
`include "crc8_frame_receiver_macros.svh"

module crc8_frame_receiver (
  input  logic          clk,
  input  logic          rst_n,
  crc8fr_in_if.sink     in_ch,
  crc8fr_out_if.source  out_ch,
  crc8fr_cfg_if.sink    cfg_ch
);

  crc8fr_pkg::cfg_t    cfg_r;
  crc8fr_pkg::result_t result;
  crc8fr_pkg::result_t res_r;
  logic                out_valid_r;
  logic                in_acc;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value     <= crc8fr_pkg::SYNC_RST;
      cfg_r.status_command <= crc8fr_pkg::STATUS_CMD_RST;
      cfg_r.param_command  <= crc8fr_pkg::PARAM_CMD_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        crc8fr_pkg::CFG_SYNC_VALUE:     cfg_r.sync_value     <= cfg_ch.data;
        crc8fr_pkg::CFG_STATUS_COMMAND: cfg_r.status_command <= cfg_ch.data;
        crc8fr_pkg::CFG_PARAM_COMMAND:  cfg_r.param_command  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  crc8fr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_acc),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.payload_valid  = res_r.payload_valid;
  assign out_ch.payload_byte   = res_r.payload_byte;
  assign out_ch.payload_offset = res_r.payload_offset;
  assign out_ch.frame_done     = res_r.frame_done;
  assign out_ch.crc_good       = res_r.crc_good;
  assign out_ch.frame_command  = res_r.frame_command;
  assign out_ch.frame_length   = res_r.frame_length;
  assign out_ch.deliver        = res_r.deliver;

  `CRC8FR_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_acc, out_ch.valid)
  `CRC8FR_ASSERT_NOW(a_deliver_needs_good_end, clk, rst_n, out_ch.valid && out_ch.deliver, out_ch.frame_done && out_ch.crc_good)
  `CRC8FR_ASSERT_NOW(a_deliver_cmd_ok, clk, rst_n, out_ch.valid && out_ch.deliver, (out_ch.frame_command == cfg_r.status_command) || (out_ch.frame_command == cfg_r.param_command))

endmodule
